// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

  localparam logic [3:0] PH_HUNT     = 4'd0;
  localparam logic [3:0] PH_VERSION  = 4'd1;
  localparam logic [3:0] PH_LEN_LO   = 4'd2;
  localparam logic [3:0] PH_LEN_HI   = 4'd3;
  localparam logic [3:0] PH_LEN_CS   = 4'd4;
  localparam logic [3:0] PH_TOPIC_LO = 4'd5;
  localparam logic [3:0] PH_TOPIC_HI = 4'd6;
  localparam logic [3:0] PH_PAYLOAD  = 4'd7;
  localparam logic [3:0] PH_DATA_CS  = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_VERSION  = 3'd1;
  localparam logic [2:0] ST_LEN_CS   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_DATA_CS  = 3'd4;

  localparam logic [1:0] REG_SYNC    = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAX     = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [7:0] CHECK_BASE = 8'd255;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [7:0]  version_value;
    logic [15:0] max_payload;
  } sfd_cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_topic;
    logic [15:0] frame_length;
    logic [2:0]  frame_status;
    logic        frame_last;
  } sfd_result_t;

endpackage

// ----- rtl/sfd_parser.sv -----
module sfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  sfd_pkg::sfd_cfg_t   cfg_i,
  output logic                res_valid_o,
  output sfd_pkg::sfd_result_t res_o
);
  import sfd_pkg::*;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] length_q, length_d;
  logic [15:0] topic_q, topic_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] count_inc;
  logic [7:0]  sum_add;

  assign count_inc = count_q + 16'd1;
  assign sum_add   = sum_q + byte_i;

  always_comb begin
    phase_d     = phase_q;
    length_d    = length_q;
    topic_d     = topic_q;
    count_d     = count_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_VERSION: begin
        if (byte_i != cfg_i.version_value) begin
          res_valid_o        = 1'b1;
          res_o.item_kind    = KIND_END;
          res_o.frame_status = ST_VERSION;
          res_o.frame_last   = 1'b1;
          phase_d            = PH_HUNT;
        end else begin
          phase_d = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        length_d = {8'd0, byte_i};
        sum_d    = byte_i;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d = {byte_i, length_q[7:0]};
        sum_d    = sum_add;
        phase_d  = PH_LEN_CS;
      end
      PH_LEN_CS: begin
        if (byte_i != (CHECK_BASE - sum_q)) begin
          res_valid_o        = 1'b1;
          res_o.item_kind    = KIND_END;
          res_o.frame_length = length_q;
          res_o.frame_status = ST_LEN_CS;
          res_o.frame_last   = 1'b1;
          phase_d            = PH_HUNT;
        end else if (length_q > cfg_i.max_payload) begin
          res_valid_o        = 1'b1;
          res_o.item_kind    = KIND_END;
          res_o.frame_length = length_q;
          res_o.frame_status = ST_TOO_LONG;
          res_o.frame_last   = 1'b1;
          phase_d            = PH_HUNT;
        end else begin
          phase_d = PH_TOPIC_LO;
        end
      end
      PH_TOPIC_LO: begin
        topic_d = {8'd0, byte_i};
        sum_d   = byte_i;
        phase_d = PH_TOPIC_HI;
      end
      PH_TOPIC_HI: begin
        topic_d = {byte_i, topic_q[7:0]};
        sum_d   = sum_add;
        count_d = '0;
        phase_d = (length_q == 16'd0) ? PH_DATA_CS : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_d              = sum_add;
        count_d            = count_inc;
        if (count_inc == length_q) begin
          phase_d = PH_DATA_CS;
        end
        res_valid_o        = 1'b1;
        res_o.item_kind    = KIND_PAYLOAD;
        res_o.payload_byte = byte_i;
        res_o.frame_topic  = topic_q;
        res_o.frame_length = length_q;
      end
      PH_DATA_CS: begin
        res_valid_o        = 1'b1;
        res_o.item_kind    = KIND_END;
        res_o.frame_topic  = topic_q;
        res_o.frame_length = length_q;
        res_o.frame_status = (byte_i == (CHECK_BASE - sum_q)) ? ST_OK : ST_DATA_CS;
        res_o.frame_last   = 1'b1;
        phase_d            = PH_HUNT;
      end
      default: begin
        // hunting: anything but sync is dropped
        phase_d = (byte_i == cfg_i.sync_value) ? PH_VERSION : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      length_q <= '0;
      topic_q  <= '0;
      count_q  <= '0;
      sum_q    <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      topic_q  <= topic_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
    end
  end

endmodule

// ----- rtl/sfd_out_reg.sv -----
module sfd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  sfd_pkg::sfd_result_t res_i,
  output logic                 slot_free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfd_pkg::sfd_result_t res_o
);
  import sfd_pkg::*;

  logic        valid_q;
  sfd_result_t data_q;

  // slot opens when empty or when the held word leaves this edge
  assign slot_free_o = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

// ----- rtl/serial_frame_deframer_top.sv -----
// serial frame deframer
// input channel: one stream byte per word on in_byte_i, in_valid_i / in_stall_o.
// output channel: one result word per payload byte (item_kind_o = 0) and one
// closing word per frame (item_kind_o = 1, frame_last_o = 1) with topic, length
// and status. a non-ok status tells the consumer to drop that frame's payload.
// config port: cfg_we_i with cfg_idx_i 0 sync value, 1 version value,
// 2 max payload length; cfg_data_i low bits hold the value. write while idle.
// a byte accepted into the input register is parsed from there and its result,
// if any, is then registered in the output register before it shows on the output.
// throughput: one byte per cycle while the output is not stalled; the frame
// phase, length, topic, byte count and running checksum all update in the single
// parse step between the input register and the output register.
// sync hunting and header bytes that pass every check produce no output word.
// reset: hunting for sync, registers back to sync 255, version 254, max 512,
// both pipeline registers empty.
// receiver stall: the output register holds its word and the parse step waits;
// in_stall_o rises at once when the input register holds a byte, otherwise one
// more byte is taken into the input register first.
module serial_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] frame_topic_o,
  output logic [15:0] frame_length_o,
  output logic [2:0]  frame_status_o,
  output logic        frame_last_o
);
  import sfd_pkg::*;

  sfd_cfg_t    cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        slot_free;
  logic        fire;
  logic        res_valid;
  sfd_result_t res;
  sfd_result_t out_res;

  assign fire       = in_valid_q && slot_free;
  assign in_stall_o = in_valid_q && !slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value    <= 8'd255;
      cfg_q.version_value <= 8'd254;
      cfg_q.max_payload   <= 16'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC:    cfg_q.sync_value    <= cfg_data_i[7:0];
        REG_VERSION: cfg_q.version_value <= cfg_data_i[7:0];
        REG_MAX:     cfg_q.max_payload   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  sfd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  sfd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(fire && res_valid),
    .res_i      (res),
    .slot_free_o(slot_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (out_res)
  );

  assign item_kind_o    = out_res.item_kind;
  assign payload_byte_o = out_res.payload_byte;
  assign frame_topic_o  = out_res.frame_topic;
  assign frame_length_o = out_res.frame_length;
  assign frame_status_o = out_res.frame_status;
  assign frame_last_o   = out_res.frame_last;

endmodule

// ----- rtl/sfd_checker.sv -----
module sfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        item_kind_i,
  input logic [7:0]  payload_byte_i,
  input logic [2:0]  frame_status_i,
  input logic        frame_last_i
);
  import sfd_pkg::*;

  // closing word and only the closing word carries last
  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frame_last_i == item_kind_i))
    else $error("frame_last and item_kind disagree");

  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && item_kind_i == KIND_PAYLOAD) |-> (frame_status_i == ST_OK))
    else $error("payload word with nonzero status");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && item_kind_i == KIND_END) |->
      (payload_byte_i == 8'd0 &&
       (frame_status_i == ST_OK || frame_status_i == ST_VERSION ||
        frame_status_i == ST_LEN_CS || frame_status_i == ST_TOO_LONG ||
        frame_status_i == ST_DATA_CS)))
    else $error("closing word with bad status or payload byte");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=>
      (out_valid_i && $stable(item_kind_i) && $stable(payload_byte_i)))
    else $error("stalled output word changed");

endmodule

bind serial_frame_deframer_top sfd_checker u_sfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .item_kind_i   (item_kind_o),
  .payload_byte_i(payload_byte_o),
  .frame_status_i(frame_status_o),
  .frame_last_i  (frame_last_o)
);
